/* src/fet_pkg.sv */
// fet_pkg: shared types, constants and helpers for the fractal escape-time engine.
// No dependencies; the RTL files refer to it by scoped names, the testbench imports it.
package fet_pkg;

  localparam int MAX_ITER = 256;
  localparam int Q_W      = 32;
  localparam int FRAC     = 28;
  localparam int PW       = 2 * Q_W;
  localparam int ESC_BIT  = 58;
  localparam int COL_W    = 10;
  localparam int ROW_W    = 10;
  localparam int SC_W     = 9;
  localparam int EC_W     = 9;
  localparam int IDX_W    = 3;
  localparam int CFG_W    = 32;
  localparam int FP_W     = Q_W + COL_W + 1;
  localparam int SAT_W    = FP_W + 1;
  localparam int CNT_W    = ($clog2(MAX_ITER + 1) > SC_W) ? $clog2(MAX_ITER + 1) : SC_W;
  localparam int FQ_DEPTH = 4;
  localparam int FQ_AW    = $clog2(FQ_DEPTH);

  localparam logic [1:0] MODE_JULIA = 2'd1;
  localparam logic [1:0] MODE_SHIP  = 2'd2;

  typedef logic signed [Q_W-1:0] q_t;

  typedef enum logic [IDX_W-1:0] {
    REG_MODE     = 3'd0,
    REG_X_ORIGIN = 3'd1,
    REG_Y_ORIGIN = 3'd2,
    REG_X_STEP   = 3'd3,
    REG_Y_STEP   = 3'd4,
    REG_JULIA_RE = 3'd5,
    REG_JULIA_IM = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0] fractal_mode;
    q_t         x_origin;
    q_t         y_origin;
    q_t         x_step;
    q_t         y_step;
    q_t         julia_const_re;
    q_t         julia_const_im;
  } cfg_t;

  typedef struct packed {
    q_t               zr;
    q_t               zi;
    q_t               cr;
    q_t               ci;
    logic             ship;
    logic [CNT_W-1:0] count;
  } job_t;

  typedef enum logic [1:0] {
    E_IDLE,
    E_MUL,
    E_ADD,
    E_HOLD
  } eng_state_t;

  localparam logic signed [SAT_W-1:0] Q_MAX_W =
    {{(SAT_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
  localparam logic signed [SAT_W-1:0] Q_MIN_W =
    {{(SAT_W-Q_W+1){1'b1}}, {(Q_W-1){1'b0}}};

  function automatic q_t sat_q(input logic signed [SAT_W-1:0] v);
    q_t res;
    if (v > Q_MAX_W) begin
      res = {1'b0, {(Q_W-1){1'b1}}};
    end else if (v < Q_MIN_W) begin
      res = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      res = v[Q_W-1:0];
    end
    return res;
  endfunction

endpackage

/* src/fet_if.sv */
// fet_if: valid/ready channel interfaces for pixel requests and escape counts.
// Depends on fet_pkg for field widths.
interface fet_in_if;
  logic                      valid;
  logic                      ready;
  logic [fet_pkg::COL_W-1:0] pixel_column;
  logic [fet_pkg::ROW_W-1:0] pixel_row;
  logic [fet_pkg::SC_W-1:0]  start_count;

  modport source (output valid, pixel_column, pixel_row, start_count, input ready);
  modport sink   (input valid, pixel_column, pixel_row, start_count, output ready);
endinterface

interface fet_out_if;
  logic                     valid;
  logic                     ready;
  logic [fet_pkg::EC_W-1:0] escape_count;

  modport source (output valid, escape_count, input ready);
  modport sink   (input valid, escape_count, output ready);
endinterface

/* src/fractal_escape_time_engine_top.sv */
// fractal_escape_time_engine_top: escape-time engine for Mandelbrot, Julia and Burning Ship.
// A request is registered in the front end and queued, then iterated by the engine; the result
// leaves through an output register. One job at a time runs in the single two-phase iteration
// engine (multiply cycle, then add/escape/saturate cycle); the front end and job queue run ahead.
// Reset: synchronous, active low; clears config registers, queue, engine state, output valid.
// Depends on fet_pkg, fet_if, fet_queue, fet_front, fet_engine.
module fractal_escape_time_engine_top (
  input  logic                        clk,
  input  logic                        rst_n,
  fet_in_if.sink                      in_ch,
  fet_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [fet_pkg::IDX_W-1:0]   cfg_index,
  input  logic [fet_pkg::CFG_W-1:0]   cfg_wdata
);

  fet_pkg::cfg_t cfg_r;
  logic          q_wr_valid, q_wr_ready, q_rd_valid, q_rd_ready;
  fet_pkg::job_t q_wr_job, q_rd_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (fet_pkg::cfg_idx_t'(cfg_index))
        fet_pkg::REG_MODE:     cfg_r.fractal_mode   <= cfg_wdata[1:0];
        fet_pkg::REG_X_ORIGIN: cfg_r.x_origin       <= cfg_wdata;
        fet_pkg::REG_Y_ORIGIN: cfg_r.y_origin       <= cfg_wdata;
        fet_pkg::REG_X_STEP:   cfg_r.x_step         <= cfg_wdata;
        fet_pkg::REG_Y_STEP:   cfg_r.y_step         <= cfg_wdata;
        fet_pkg::REG_JULIA_RE: cfg_r.julia_const_re <= cfg_wdata;
        fet_pkg::REG_JULIA_IM: cfg_r.julia_const_im <= cfg_wdata;
        default: ;
      endcase
    end
  end

  fet_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_ch    (in_ch),
    .wr_valid (q_wr_valid),
    .wr_ready (q_wr_ready),
    .wr_job   (q_wr_job)
  );

  fet_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (q_wr_valid),
    .wr_ready (q_wr_ready),
    .wr_job   (q_wr_job),
    .rd_valid (q_rd_valid),
    .rd_ready (q_rd_ready),
    .rd_job   (q_rd_job)
  );

  fet_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_valid (q_rd_valid),
    .rd_ready (q_rd_ready),
    .rd_job   (q_rd_job),
    .out_ch   (out_ch)
  );

  a_rst_out_idle: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

  a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
    (q_wr_valid && q_wr_ready) |=> q_rd_valid)
    else $error("queued job not visible to engine");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (q_wr_valid && !q_wr_ready))
    else $error("request stalled without full queue");

endmodule

/* src/fet_queue.sv */
// fet_queue: small job FIFO between the mapping front end and the iteration engine.
// Depends on fet_pkg (job_t, FQ_DEPTH).
module fet_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  fet_pkg::job_t wr_job,
  output logic          rd_valid,
  input  logic          rd_ready,
  output fet_pkg::job_t rd_job
);

  fet_pkg::job_t                mem_r [fet_pkg::FQ_DEPTH];
  logic [fet_pkg::FQ_AW-1:0]    wptr_r, wptr_nxt;
  logic [fet_pkg::FQ_AW-1:0]    rptr_r, rptr_nxt;
  logic [fet_pkg::FQ_AW:0]      fill_r, fill_nxt;
  logic                         push, pop;

  assign wr_ready = (fill_r != (fet_pkg::FQ_AW+1)'(fet_pkg::FQ_DEPTH));
  assign rd_valid = (fill_r != '0);
  assign rd_job   = mem_r[rptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    fill_nxt = fill_r;
    if (push) begin
      wptr_nxt = (wptr_r == fet_pkg::FQ_AW'(fet_pkg::FQ_DEPTH-1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == fet_pkg::FQ_AW'(fet_pkg::FQ_DEPTH-1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wr_job;
    end
  end

endmodule

/* src/fet_front.sv */
// fet_front: accepts pixel requests, maps them to Q4.28 points and builds jobs.
// Depends on fet_pkg and fet_in_if; feeds fet_queue.
module fet_front (
  input  logic          clk,
  input  logic          rst_n,
  input  fet_pkg::cfg_t cfg,
  fet_in_if.sink        in_ch,
  output logic          wr_valid,
  input  logic          wr_ready,
  output fet_pkg::job_t wr_job
);

  logic                             s1_v_r, s1_v_nxt;
  logic signed [fet_pkg::FP_W-1:0]  xp_r, yp_r;
  logic [fet_pkg::SC_W-1:0]         sc_r;
  logic                             accept;
  fet_pkg::q_t                      pre, pim;

  assign in_ch.ready = !s1_v_r || wr_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign wr_valid    = s1_v_r;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (wr_ready) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      xp_r <= $signed({1'b0, in_ch.pixel_column}) * $signed(cfg.x_step);
      yp_r <= $signed({1'b0, in_ch.pixel_row}) * $signed(cfg.y_step);
      sc_r <= in_ch.start_count;
    end
  end

  assign pre = fet_pkg::sat_q(fet_pkg::SAT_W'(xp_r) + fet_pkg::SAT_W'($signed(cfg.x_origin)));
  assign pim = fet_pkg::sat_q(fet_pkg::SAT_W'(yp_r) + fet_pkg::SAT_W'($signed(cfg.y_origin)));

  always_comb begin
    wr_job.ship  = (cfg.fractal_mode == fet_pkg::MODE_SHIP);
    wr_job.count = fet_pkg::CNT_W'(sc_r);
    if (cfg.fractal_mode == fet_pkg::MODE_JULIA) begin
      wr_job.zr = pre;
      wr_job.zi = pim;
      wr_job.cr = cfg.julia_const_re;
      wr_job.ci = cfg.julia_const_im;
    end else begin
      wr_job.zr = '0;
      wr_job.zi = '0;
      wr_job.cr = pre;
      wr_job.ci = pim;
    end
  end

endmodule

/* src/fet_engine.sv */
// fet_engine: iterates z = z^2 + c per job in a multiply state and an add state, with an output register.
// Depends on fet_pkg and fet_out_if; pulls jobs from fet_queue.
module fet_engine (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_valid,
  output logic          rd_ready,
  input  fet_pkg::job_t rd_job,
  fet_out_if.source     out_ch
);

  localparam int PW   = fet_pkg::PW;
  localparam int SW   = fet_pkg::SAT_W;
  localparam int QW   = fet_pkg::Q_W;
  localparam int FR   = fet_pkg::FRAC;

  fet_pkg::eng_state_t          state_r, state_nxt;
  fet_pkg::q_t                  zr_r, zr_nxt, zi_r, zi_nxt;
  fet_pkg::q_t                  cr_r, cr_nxt, ci_r, ci_nxt;
  logic                         ship_r, ship_nxt;
  logic [fet_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [PW-1:0]                r2_r, i2_r, p_r;
  logic                         neg_r;
  logic                         out_v_r, out_v_nxt;
  logic [fet_pkg::EC_W-1:0]     out_d_r, out_d_nxt;

  logic [QW-1:0]                zr_u, zi_u, ar, ai;
  logic [PW-1:0]                sum, pm;
  logic signed [PW-1:0]         diff;
  logic signed [SW-1:0]         nr_raw, ni_raw;
  logic                         stop, slot_free, load_out;

  assign zr_u = zr_r;
  assign zi_u = zi_r;
  assign ar   = zr_u[QW-1] ? (QW'(0) - zr_u) : zr_u;
  assign ai   = zi_u[QW-1] ? (QW'(0) - zi_u) : zi_u;

  always_ff @(posedge clk) begin
    if (state_r == fet_pkg::E_MUL) begin
      r2_r  <= PW'(ar) * PW'(ar);
      i2_r  <= PW'(ai) * PW'(ai);
      p_r   <= PW'(ar) * PW'(ai);
      neg_r <= zr_u[QW-1] ^ zi_u[QW-1];
    end
  end

  assign sum  = r2_r + i2_r;
  assign diff = $signed(r2_r) - $signed(i2_r);
  assign pm   = neg_r ? (PW'(0) - p_r) : p_r;
  assign stop = (count_r >= fet_pkg::CNT_W'(fet_pkg::MAX_ITER)) || (|sum[PW-1:fet_pkg::ESC_BIT]);

  always_comb begin
    nr_raw = SW'($signed(diff[PW-1:FR])) + SW'(cr_r);
    if (ship_r) begin
      ni_raw = SW'(ci_r) - SW'($signed({1'b0, p_r[PW-1:FR-1]}));
    end else begin
      ni_raw = SW'($signed(pm[PW-1:FR-1])) + SW'(ci_r);
    end
  end

  assign slot_free    = !out_v_r || out_ch.ready;
  assign out_ch.valid = out_v_r;
  assign out_ch.escape_count = out_d_r;

  always_comb begin
    state_nxt = state_r;
    zr_nxt    = zr_r;
    zi_nxt    = zi_r;
    cr_nxt    = cr_r;
    ci_nxt    = ci_r;
    ship_nxt  = ship_r;
    count_nxt = count_r;
    rd_ready  = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      fet_pkg::E_IDLE: begin
        rd_ready = 1'b1;
        if (rd_valid) begin
          zr_nxt    = rd_job.zr;
          zi_nxt    = rd_job.zi;
          cr_nxt    = rd_job.cr;
          ci_nxt    = rd_job.ci;
          ship_nxt  = rd_job.ship;
          count_nxt = rd_job.count;
          state_nxt = fet_pkg::E_MUL;
        end
      end
      fet_pkg::E_MUL: begin
        state_nxt = fet_pkg::E_ADD;
      end
      fet_pkg::E_ADD: begin
        if (stop) begin
          if (slot_free) begin
            load_out  = 1'b1;
            state_nxt = fet_pkg::E_IDLE;
          end else begin
            state_nxt = fet_pkg::E_HOLD;
          end
        end else begin
          zr_nxt    = fet_pkg::sat_q(nr_raw);
          zi_nxt    = fet_pkg::sat_q(ni_raw);
          count_nxt = count_r + 1'b1;
          state_nxt = fet_pkg::E_MUL;
        end
      end
      fet_pkg::E_HOLD: begin
        if (slot_free) begin
          load_out  = 1'b1;
          state_nxt = fet_pkg::E_IDLE;
        end
      end
      default: state_nxt = fet_pkg::E_IDLE;
    endcase
  end

  always_comb begin
    out_v_nxt = out_v_r;
    out_d_nxt = out_d_r;
    if (load_out) begin
      out_v_nxt = 1'b1;
      out_d_nxt = count_r[fet_pkg::EC_W-1:0];
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fet_pkg::E_IDLE;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    zr_r    <= zr_nxt;
    zi_r    <= zi_nxt;
    cr_r    <= cr_nxt;
    ci_r    <= ci_nxt;
    ship_r  <= ship_nxt;
    count_r <= count_nxt;
    out_d_r <= out_d_nxt;
  end

endmodule

/* test/fractal_escape_time_engine_top_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for fractal_escape_time_engine_top: directed and random pixel
// requests under several register settings, checked against a local escape-time predictor.
// Depends on fet_pkg, fet_if and the engine RTL.
module fractal_escape_time_engine_top_test;
  import fet_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int TAIL_CYCLES = 2 * MAX_ITER + 16;
  localparam int MAX_REPORTS = 200;

  localparam logic [1:0] MODE_MANDEL = 2'd0;
  localparam logic [1:0] MODE_SPARE  = 2'd3;
  localparam logic [IDX_W-1:0] REG_NONE = 3'd7;

  localparam int Q_ONE      = 1 << FRAC;
  localparam q_t Q_MOST_POS = 32'sh7FFF_FFFF;
  localparam q_t Q_MOST_NEG = 32'sh8000_0000;
  localparam longint Q_HI   = 64'sd2147483647;
  localparam longint Q_LO   = -64'sd2147483648;
  localparam longint unsigned ESCAPE_SQ = 64'd1 << ESC_BIT;

  typedef struct {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [SC_W-1:0]  start;
    logic [EC_W-1:0]  escape;
  } pixel_expect_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  fet_in_if  in_ch();
  fet_out_if out_ch();

  fractal_escape_time_engine_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  cfg_t model_cfg;
  pixel_expect_t pending_counts[$];
  int error_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_request = 0;
  int stall_left = 0;
  int cycle_count;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint clamp_q(input longint v);
    if (v > Q_HI) begin
      return Q_HI;
    end
    if (v < Q_LO) begin
      return Q_LO;
    end
    return v;
  endfunction

  function automatic logic [EC_W-1:0] predict_escape(input logic [COL_W-1:0] col,
                                                     input logic [ROW_W-1:0] row,
                                                     input logic [SC_W-1:0] start);
    longint pt_re, pt_im, zr, zi, cr, ci, nr, ni;
    longint unsigned mag_r, mag_i, sq_r, sq_i;
    int unsigned count;
    bit ship;
    pt_re = clamp_q(longint'(col) * longint'($signed(model_cfg.x_step)) +
                    longint'($signed(model_cfg.x_origin)));
    pt_im = clamp_q(longint'(row) * longint'($signed(model_cfg.y_step)) +
                    longint'($signed(model_cfg.y_origin)));
    ship = (model_cfg.fractal_mode == MODE_SHIP);
    if (model_cfg.fractal_mode == MODE_JULIA) begin
      zr = pt_re;
      zi = pt_im;
      cr = longint'($signed(model_cfg.julia_const_re));
      ci = longint'($signed(model_cfg.julia_const_im));
    end else begin
      zr = 0;
      zi = 0;
      cr = pt_re;
      ci = pt_im;
    end
    count = start;
    while (count < MAX_ITER) begin
      mag_r = (zr < 0) ? -zr : zr;
      mag_i = (zi < 0) ? -zi : zi;
      sq_r = mag_r * mag_r;
      sq_i = mag_i * mag_i;
      if (sq_r + sq_i >= ESCAPE_SQ) begin
        break;
      end
      nr = clamp_q(((longint'(sq_r) - longint'(sq_i)) >>> FRAC) + cr);
      if (ship) begin
        ni = clamp_q(ci - longint'((mag_r * mag_i) >> (FRAC - 1)));
      end else begin
        ni = clamp_q(((zr * zi) >>> (FRAC - 1)) + ci);
      end
      zr = nr;
      zi = ni;
      count++;
    end
    return count[EC_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_REPORTS) begin
      $display("ERROR @%0d: %s", cycle_count, msg);
    end
    error_count++;
  endtask

  always @(posedge clk) begin : result_monitor
    pixel_expect_t head;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_counts.size() == 0) begin
        report_mismatch($sformatf("escape count %0d with no request pending",
                                  out_ch.escape_count));
      end else begin
        head = pending_counts.pop_front();
        if (out_ch.escape_count !== head.escape) begin
          report_mismatch($sformatf("col %0d row %0d start %0d: count %0d, expected %0d",
                                    head.col, head.row, head.start,
                                    out_ch.escape_count, head.escape));
        end
      end
    end
  end

  always @(posedge clk) begin : receiver
    if (stall_request > 0) begin
      stall_left = stall_request;
      stall_request = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ERROR: timeout after %0d cycles, %0d requests pending",
             cycle_count, pending_counts.size());
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_pixel(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
                            input logic [SC_W-1:0] start);
    pixel_expect_t e;
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid        <= 1'b1;
    in_ch.pixel_column <= col;
    in_ch.pixel_row    <= row;
    in_ch.start_count  <= start;
    do @(posedge clk); while (!in_ch.ready);
    e.col    = col;
    e.row    = row;
    e.start  = start;
    e.escape = predict_escape(col, row, start);
    pending_counts.push_back(e);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_counts.size() != 0);
  endtask

  task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Writes every register, then a stray write to the unused index.
  task automatic set_config(input logic [1:0] mode, input q_t xo, input q_t yo,
                            input q_t xs, input q_t ys, input q_t jr, input q_t ji);
    logic [CFG_W-1:0] mode_word;
    wait_drained();
    mode_word = $urandom;
    mode_word[1:0] = mode;
    put_reg(REG_MODE, mode_word);
    put_reg(REG_X_ORIGIN, xo);
    put_reg(REG_Y_ORIGIN, yo);
    put_reg(REG_X_STEP, xs);
    put_reg(REG_Y_STEP, ys);
    put_reg(REG_JULIA_RE, jr);
    put_reg(REG_JULIA_IM, ji);
    put_reg(REG_NONE, $urandom);
    cfg_we <= 1'b0;
    model_cfg.fractal_mode   = mode;
    model_cfg.x_origin       = xo;
    model_cfg.y_origin       = yo;
    model_cfg.x_step         = xs;
    model_cfg.y_step         = ys;
    model_cfg.julia_const_re = jr;
    model_cfg.julia_const_im = ji;
  endtask

  function automatic q_t pick_extreme();
    case ($urandom_range(4))
      0: return Q_MOST_NEG;
      1: return Q_MOST_POS;
      2: return q_t'(0);
      3: return q_t'(1);
      default: return q_t'(-1);
    endcase
  endfunction

  function automatic q_t random_step();
    int s;
    s = $urandom_range(0, Q_ONE >>> 8);
    if ($urandom_range(1)) begin
      s = -s;
    end
    return q_t'(s);
  endfunction

  function automatic logic [COL_W-1:0] pick_coord();
    if ($urandom_range(15) == 0) begin
      return $urandom_range(1) ? '1 : '0;
    end
    return COL_W'($urandom_range(0, (1 << COL_W) - 1));
  endfunction

  function automatic logic [SC_W-1:0] pick_start();
    case ($urandom_range(9))
      0, 1, 2, 3: return '0;
      4, 5, 6:    return SC_W'($urandom_range(150, MAX_ITER - 1));
      7:          return SC_W'($urandom_range(MAX_ITER, (1 << SC_W) - 1));
      8:          return $urandom_range(1) ? SC_W'(MAX_ITER - 1) : SC_W'(MAX_ITER);
      default:    return SC_W'($urandom_range(0, (1 << SC_W) - 1));
    endcase
  endfunction

  task automatic random_config();
    logic [1:0] mode;
    q_t xo, yo, xs, ys, jr, ji;
    int kind;
    kind = $urandom_range(9);
    mode = 2'($urandom_range(3));
    if (kind == 0) begin
      xo = $urandom;
      yo = $urandom;
      xs = $urandom;
      ys = $urandom;
      jr = $urandom;
      ji = $urandom;
    end else if (kind == 1) begin
      xo = pick_extreme();
      yo = pick_extreme();
      xs = pick_extreme();
      ys = pick_extreme();
      jr = pick_extreme();
      ji = pick_extreme();
    end else begin
      xo = q_t'(int'($urandom_range(0, 3 * Q_ONE)) - 2 * Q_ONE);
      yo = q_t'(int'($urandom_range(0, 3 * Q_ONE)) - (3 * Q_ONE) / 2);
      xs = random_step();
      ys = random_step();
      jr = q_t'(int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE);
      ji = q_t'(int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE);
    end
    set_config(mode, xo, yo, xs, ys, jr, ji);
  endtask

  task automatic apply_reset();
    model_cfg = '0;
    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  // All registers zero after reset: c = 0, every pixel runs to the limit.
  task automatic test_reset_defaults();
    send_pixel('0, '0, '0);
    send_pixel('1, '1, '0);
    send_pixel(10'd5, 10'd5, SC_W'(MAX_ITER - 1));
    send_pixel('0, '0, SC_W'(MAX_ITER));
    send_pixel('0, '1, '1);
  endtask

  task automatic test_mandelbrot_view();
    set_config(MODE_MANDEL, q_t'(-2 * Q_ONE), q_t'(-(3 * Q_ONE) / 2),
               q_t'(3 * (Q_ONE >>> 10)), q_t'(3 * (Q_ONE >>> 10)), q_t'(0), q_t'(0));
    send_pixel('0, '0, '0);
    send_pixel('1, '0, '0);
    send_pixel('0, '1, '0);
    send_pixel(10'd683, 10'd512, '0);
    send_pixel(10'd0, 10'd512, '0);
    send_pixel(10'd600, 10'd700, 9'd100);
  endtask

  task automatic test_julia_view();
    set_config(MODE_JULIA, q_t'(-(3 * Q_ONE) / 2), q_t'(-(3 * Q_ONE) / 2),
               q_t'(3 * (Q_ONE >>> 10)), q_t'(3 * (Q_ONE >>> 10)),
               q_t'(-214748365), q_t'(41875931));
    // corner starts outside the escape circle
    send_pixel('0, '0, 9'd37);
    send_pixel(10'd512, 10'd512, '0);
    send_pixel(10'd300, 10'd600, '0);
    send_pixel('1, '1, '0);
  endtask

  task automatic test_burning_ship_view();
    set_config(MODE_SHIP, q_t'(-2 * Q_ONE), q_t'(-2 * Q_ONE),
               q_t'(Q_ONE >>> 8), q_t'(Q_ONE >>> 8), Q_MOST_POS, Q_MOST_NEG);
    send_pixel(10'd400, 10'd500, '0);
    send_pixel(10'd450, 10'd300, '0);
    send_pixel(10'd100, 10'd900, '0);
  endtask

  task automatic test_spare_mode();
    set_config(MODE_SPARE, q_t'(-2 * Q_ONE), q_t'(-(3 * Q_ONE) / 2),
               q_t'(3 * (Q_ONE >>> 10)), q_t'(3 * (Q_ONE >>> 10)), Q_ONE, Q_ONE);
    send_pixel(10'd683, 10'd512, '0);
    send_pixel(10'd200, 10'd400, '0);
  endtask

  task automatic test_saturation_extremes();
    set_config(MODE_MANDEL, Q_MOST_POS, Q_MOST_NEG, Q_MOST_POS, Q_MOST_NEG, q_t'(0), q_t'(0));
    send_pixel('0, '0, '0);
    send_pixel('1, '1, 9'd3);
    set_config(MODE_JULIA, q_t'(32'h1E00_0000), q_t'(0), q_t'(0), q_t'(0),
               Q_MOST_POS, Q_MOST_NEG);
    send_pixel('0, '0, '0);
    send_pixel(10'd5, 10'd9, '1);
  endtask

  // Receiver holds off long enough that the engine and its queue fill up.
  task automatic test_output_stall();
    int i;
    set_config(MODE_MANDEL, q_t'(-2 * Q_ONE), q_t'(-(3 * Q_ONE) / 2),
               q_t'(3 * (Q_ONE >>> 10)), q_t'(3 * (Q_ONE >>> 10)), q_t'(0), q_t'(0));
    stall_request = 1500;
    for (i = 0; i < 16; i++) begin
      send_pixel(pick_coord(), pick_coord(), SC_W'($urandom_range(240, MAX_ITER - 1)));
    end
    wait_drained();
  endtask

  task automatic test_random_pixels(input int n_items, input int send_pct, input int recv_pct);
    int sent;
    int seg;
    int i;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < n_items) begin
      random_config();
      seg = $urandom_range(20, 80);
      for (i = 0; i < seg && sent < n_items; i++) begin
        send_pixel(pick_coord(), pick_coord(), pick_start());
        sent++;
      end
    end
  endtask

  initial begin
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= '0;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.pixel_column <= '0;
    in_ch.pixel_row    <= '0;
    in_ch.start_count  <= '0;
    send_idle_pct = 8;
    recv_idle_pct = 75;
    apply_reset();

    test_reset_defaults();
    test_mandelbrot_view();
    test_julia_view();
    test_burning_ship_view();
    test_spare_mode();
    test_saturation_extremes();
    test_output_stall();
    test_random_pixels(400, 8, 75);
    test_random_pixels(400, 75, 8);
    test_random_pixels(400, 0, 0);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
